[hdl/cc20_pkg.sv]
package cc20_pkg;

   localparam int CC20_CSR_INDEX_W = 3;
   localparam int CC20_CSR_DATA_W  = 64;

   localparam logic [CC20_CSR_INDEX_W-1:0] CC20_CSR_KEY_0      = 3'd0;
   localparam logic [CC20_CSR_INDEX_W-1:0] CC20_CSR_KEY_1      = 3'd1;
   localparam logic [CC20_CSR_INDEX_W-1:0] CC20_CSR_KEY_2      = 3'd2;
   localparam logic [CC20_CSR_INDEX_W-1:0] CC20_CSR_KEY_3      = 3'd3;
   localparam logic [CC20_CSR_INDEX_W-1:0] CC20_CSR_NONCE_LOW  = 3'd4;
   localparam logic [CC20_CSR_INDEX_W-1:0] CC20_CSR_NONCE_HIGH = 3'd5;
   localparam logic [CC20_CSR_INDEX_W-1:0] CC20_CSR_INIT_CTR   = 3'd6;

   localparam int CC20_DOUBLE_ROUNDS = 10;

   localparam logic [31:0] CC20_SIGMA_0 = 32'h61707865;
   localparam logic [31:0] CC20_SIGMA_1 = 32'h3320646e;
   localparam logic [31:0] CC20_SIGMA_2 = 32'h79622d32;
   localparam logic [31:0] CC20_SIGMA_3 = 32'h6b206574;

   typedef logic [15:0][31:0] cc20_words_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic accept;
      logic load;
      logic out_direct;
      logic qr_first;
      logic qr_second;
      logic diag;
      logic undiag;
      logic finish;
   } cc20_cmd_type;

   typedef struct packed {
      logic pos_zero;
   } cc20_status_type;

endpackage

[hdl/cc20_req_if.sv]
interface cc20_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       last_byte;

   modport source (output valid, output in_byte, output last_byte, input ready);
   modport sink   (input valid, input in_byte, input last_byte, output ready);
endinterface

[hdl/cc20_rsp_if.sv]
interface cc20_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       out_last;

   modport source (output valid, output out_byte, output out_last, input ready);
   modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

[hdl/chacha20_stream_cipher.sv]
// channel   dir  transfer                     payload
// req_chan  in   valid && ready               in_byte[7:0], last_byte
// rsp_chan  out  valid && ready               out_byte[7:0], out_last
// csr_*     in   csr_we (no wait, no read)    csr_index[2:0], csr_wdata[63:0]
//
// A byte inside a 64-byte block is taken and its result registered at the same
// edge. A byte at block position 0 first builds a keystream block on one shared
// half-quarter-round unit: 10 x (16 half steps + 2 row shifts) plus a final
// add, which registers its result; no new byte is taken until the block is done.
// Reset is synchronous and clears the CSR registers, controller state, block
// counter and position; the data and output registers are not reset.
// A result holds in the output register until taken; a new byte is taken
// only while that register is empty or being emptied in the same cycle.
module chacha20_stream_cipher (
   input  logic                                  clock,
   input  logic                                  reset,
   cc20_req_if.sink                              req_chan,
   cc20_rsp_if.source                            rsp_chan,
   input  logic                                  csr_we,
   input  logic [cc20_pkg::CC20_CSR_INDEX_W-1:0] csr_index,
   input  logic [cc20_pkg::CC20_CSR_DATA_W-1:0]  csr_wdata
);
   import cc20_pkg::*;

   cc20_cmd_type    cmd;
   cc20_status_type status;
   logic            req_ready;
   logic            rsp_valid;
   logic [7:0]      out_byte;
   logic            out_last;

   cc20_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   cc20_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .in_byte   (req_chan.in_byte),
      .last_byte (req_chan.last_byte),
      .out_byte  (out_byte),
      .out_last  (out_last),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   assign req_chan.ready    = req_ready;
   assign rsp_chan.valid    = rsp_valid;
   assign rsp_chan.out_byte = out_byte;
   assign rsp_chan.out_last = out_last;

endmodule

[hdl/cc20_ctrl.sv]
module cc20_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  cc20_pkg::cc20_status_type status,
   output cc20_pkg::cc20_cmd_type    cmd
);
   import cc20_pkg::*;

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_COL    = 6'b000010,
      S_DIAG   = 6'b000100,
      S_DIAGQ  = 6'b001000,
      S_UNDIAG = 6'b010000,
      S_FINAL  = 6'b100000
   } state_type;

   state_type  state_ff, state_in;
   logic [2:0] step_ff, step_in;
   logic [3:0] round_ff, round_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;

   assign req_ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      round_in = round_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            cmd.accept     = accept;
            cmd.load       = accept && status.pos_zero;
            cmd.out_direct = accept && !status.pos_zero;
            if (accept && status.pos_zero) begin
               state_in = S_COL;
               step_in  = '0;
               round_in = '0;
            end
         end
         S_COL: begin
            cmd.qr_first  = !step_ff[0];
            cmd.qr_second = step_ff[0];
            step_in       = step_ff + 3'd1;
            if (step_ff == 3'd7) state_in = S_DIAG;
         end
         S_DIAG: begin
            cmd.diag = 1'b1;
            state_in = S_DIAGQ;
         end
         S_DIAGQ: begin
            cmd.qr_first  = !step_ff[0];
            cmd.qr_second = step_ff[0];
            step_in       = step_ff + 3'd1;
            if (step_ff == 3'd7) state_in = S_UNDIAG;
         end
         S_UNDIAG: begin
            cmd.undiag = 1'b1;
            if (round_ff == 4'(CC20_DOUBLE_ROUNDS - 1)) begin
               state_in = S_FINAL;
            end else begin
               round_in = round_ff + 4'd1;
               state_in = S_COL;
            end
         end
         S_FINAL: begin
            cmd.finish = 1'b1;
            state_in   = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (cmd.out_direct || cmd.finish) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= '0;
         round_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         round_ff     <= round_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

[hdl/cc20_datapath.sv]
module cc20_datapath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  cc20_pkg::cc20_cmd_type                cmd,
   output cc20_pkg::cc20_status_type             status,
   input  logic [7:0]                            in_byte,
   input  logic                                  last_byte,
   output logic [7:0]                            out_byte,
   output logic                                  out_last,
   input  logic                                  csr_we,
   input  logic [cc20_pkg::CC20_CSR_INDEX_W-1:0] csr_index,
   input  logic [cc20_pkg::CC20_CSR_DATA_W-1:0]  csr_wdata
);
   import cc20_pkg::*;

   logic [63:0]    key_ff [4];
   logic [63:0]    nonce_low_ff;
   logic [31:0]    nonce_high_ff;
   logic [31:0]    init_ctr_ff;
   logic [31:0]    blk_ctr_ff, blk_ctr_in;
   logic [5:0]     pos_ff, pos_in;
   logic           active_ff, active_in;
   logic [31:0]    used_ctr_ff;
   logic [7:0]     byte_ff;
   logic           last_ff;
   logic [7:0]     out_byte_ff;
   logic           out_last_ff;
   cc20_words_type work_ff, work_in;
   cc20_words_type ks_ff;
   cc20_words_type ks_sum;
   cc20_words_type init_used;
   cc20_words_type col;
   logic [31:0]    a1, b1, c1, d1, a2, b2, c2, d2, tx;
   logic [31:0]    ks_word, ks_shift;

   function automatic cc20_words_type init_state(input logic [31:0] ctr);
      cc20_words_type s;
      s[0]  = CC20_SIGMA_0;
      s[1]  = CC20_SIGMA_1;
      s[2]  = CC20_SIGMA_2;
      s[3]  = CC20_SIGMA_3;
      s[4]  = key_ff[0][31:0];
      s[5]  = key_ff[0][63:32];
      s[6]  = key_ff[1][31:0];
      s[7]  = key_ff[1][63:32];
      s[8]  = key_ff[2][31:0];
      s[9]  = key_ff[2][63:32];
      s[10] = key_ff[3][31:0];
      s[11] = key_ff[3][63:32];
      s[12] = ctr;
      s[13] = nonce_low_ff[31:0];
      s[14] = nonce_low_ff[63:32];
      s[15] = nonce_high_ff;
      return s;
   endfunction

   assign status.pos_zero = (pos_ff == 6'd0);
   assign out_byte        = out_byte_ff;
   assign out_last        = out_last_ff;

   // quarter-round unit, one half per cycle, always on column 0
   always_comb begin
      tx = work_ff[12] ^ (work_ff[0] + work_ff[4]);
      a1 = work_ff[0] + work_ff[4];
      d1 = {tx[15:0], tx[31:16]};
      c1 = work_ff[8] + d1;
      tx = work_ff[4] ^ c1;
      b1 = {tx[19:0], tx[31:20]};

      a2 = work_ff[0] + work_ff[4];
      tx = work_ff[12] ^ a2;
      d2 = {tx[23:0], tx[31:24]};
      c2 = work_ff[8] + d2;
      tx = work_ff[4] ^ c2;
      b2 = {tx[24:0], tx[31:25]};
   end

   always_comb begin
      init_used = init_state(used_ctr_ff);
      for (int i = 0; i < 16; i++) begin
         ks_sum[i] = work_ff[i] + init_used[i];
      end
   end

   always_comb begin
      col      = work_ff;
      col[0]   = a2;
      col[4]   = b2;
      col[8]   = c2;
      col[12]  = d2;
      work_in  = work_ff;
      if (cmd.load) begin
         work_in = init_state(blk_ctr_ff);
      end else if (cmd.qr_first) begin
         work_in[0]  = a1;
         work_in[4]  = b1;
         work_in[8]  = c1;
         work_in[12] = d1;
      end else if (cmd.qr_second) begin
         // finish the quarter round, then bring the next column to the front
         for (int r = 0; r < 4; r++) begin
            for (int j = 0; j < 4; j++) begin
               work_in[4*r+j] = col[4*r+((j+1)&3)];
            end
         end
      end else if (cmd.diag) begin
         for (int r = 0; r < 4; r++) begin
            for (int j = 0; j < 4; j++) begin
               work_in[4*r+j] = work_ff[4*r+((j+r)&3)];
            end
         end
      end else if (cmd.undiag) begin
         for (int r = 0; r < 4; r++) begin
            for (int j = 0; j < 4; j++) begin
               work_in[4*r+j] = work_ff[4*r+((j+4-r)&3)];
            end
         end
      end
   end

   always_comb begin
      pos_in     = pos_ff;
      active_in  = active_ff;
      blk_ctr_in = blk_ctr_ff;
      if (cmd.accept) begin
         active_in = !last_byte;
         if (last_byte) begin
            pos_in     = '0;
            blk_ctr_in = init_ctr_ff;
         end else begin
            pos_in = pos_ff + 6'd1;
            if (status.pos_zero) blk_ctr_in = blk_ctr_ff + 32'd1;
         end
      end else if (csr_we && csr_index == CC20_CSR_INIT_CTR && !active_ff) begin
         blk_ctr_in = csr_wdata[31:0];
      end
   end

   assign ks_word  = ks_ff[pos_ff[5:2]];
   assign ks_shift = ks_word >> {pos_ff[1:0], 3'b000};

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) key_ff[i] <= '0;
         nonce_low_ff  <= '0;
         nonce_high_ff <= '0;
         init_ctr_ff   <= '0;
         blk_ctr_ff    <= '0;
         pos_ff        <= '0;
         active_ff     <= 1'b0;
      end else begin
         blk_ctr_ff <= blk_ctr_in;
         pos_ff     <= pos_in;
         active_ff  <= active_in;
         if (csr_we) begin
            case (csr_index)
               CC20_CSR_KEY_0:      key_ff[0]     <= csr_wdata;
               CC20_CSR_KEY_1:      key_ff[1]     <= csr_wdata;
               CC20_CSR_KEY_2:      key_ff[2]     <= csr_wdata;
               CC20_CSR_KEY_3:      key_ff[3]     <= csr_wdata;
               CC20_CSR_NONCE_LOW:  nonce_low_ff  <= csr_wdata;
               CC20_CSR_NONCE_HIGH: nonce_high_ff <= csr_wdata[31:0];
               CC20_CSR_INIT_CTR:   init_ctr_ff   <= csr_wdata[31:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      if (cmd.load) begin
         used_ctr_ff <= blk_ctr_ff;
         byte_ff     <= in_byte;
         last_ff     <= last_byte;
      end
      if (cmd.out_direct) begin
         out_byte_ff <= in_byte ^ ks_shift[7:0];
         out_last_ff <= last_byte;
      end else if (cmd.finish) begin
         ks_ff       <= ks_sum;
         out_byte_ff <= byte_ff ^ ks_sum[0][7:0];
         out_last_ff <= last_ff;
      end
   end

endmodule
